// ===== hdl/ket_pkg.sv =====
// Shared types and constants for the keyed entry table.
package ket_pkg;

  localparam int unsigned CFG_W    = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_DEL = 2'd1,
    REQ_GET = 2'd2,
    REQ_UPD = 2'd3
  } ket_req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_ADD_DUP  = 3'd2,
    ST_DEL_MISS = 3'd3,
    ST_GET_MISS = 3'd4,
    ST_UPD_DUP  = 3'd5,
    ST_UPD_MISS = 3'd6
  } ket_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new request and reset the walk
    logic walk;     // step the read pointer through the live entries
    logic commit;   // decide the outcome, write one entry on a successful add or update
    logic shift;    // walk moves entries down one place instead of comparing
    logic shrink;   // drop one live entry at the end of a shift
    logic publish;  // copy the result into the output register
  } ket_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;  // the walk has read and processed the last live entry
    logic do_shift;   // the request is a delete that found its key
  } ket_stat_t;

endpackage

// ===== hdl/ket_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ket_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ket_ctrl.sv =====
// Request sequencer of the keyed entry table: scan, commit, shift, publish.
module ket_ctrl import ket_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ket_stat_t stat_i,
  output ket_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_SCAN:   cmd_o.walk = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      S_SHIFT: begin
        cmd_o.walk   = 1'b1;
        cmd_o.shift  = 1'b1;
        cmd_o.shrink = stat_i.walk_done;
      end
      S_FINISH: cmd_o.publish = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result replaces one that is taken in the same cycle.
      priority if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat_i.walk_done) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_q <= stat_i.do_shift ? S_SHIFT : S_FINISH;
        end
        S_SHIFT: begin
          if (stat_i.walk_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ket_dp.sv =====
// Datapath of the keyed entry table: stores, read walk, compare and result registers.
module ket_dp import ket_pkg::*; #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned KEY_WIDTH     = 16,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ket_cmd_t                 cmd_i,
  output ket_stat_t                stat_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic [1:0]               req_type_i,
  input  logic [KEY_WIDTH-1:0]     lookup_key_i,
  input  logic [KEY_WIDTH-1:0]     replacement_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] entry_payload_i,
  output logic [2:0]               status_o,
  output logic [PAYLOAD_WIDTH-1:0] found_payload_o,
  output logic [COUNT_W-1:0]       entry_count_o
);

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;

  // Control state.
  logic [CFG_W-1:0] cap_q;
  logic [CW-1:0]    live_q, live_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             cmp_vld_q;
  logic             hit_q, dup_q;

  // Request and result payload.
  ket_req_e           req_q;
  logic [KEY_WIDTH-1:0]     key_q, new_key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q, found_pay_q;
  logic [IW-1:0]            cmp_idx_q, slot_q;
  ket_status_e              res_status_q, out_status_q;
  logic [PAYLOAD_WIDTH-1:0] res_found_q, out_found_q;
  logic [COUNT_W-1:0]       out_count_q;

  // Store ports.
  logic                     rd_en, wr_en;
  logic [IW-1:0]            wr_addr;
  logic [KEY_WIDTH-1:0]     wr_key, rd_key;
  logic [PAYLOAD_WIDTH-1:0] wr_pay, rd_pay;

  logic        full, match_key, match_new, is_slot, dup_set;
  logic        commit_wr, shift_wr, add_ok;
  ket_status_e status_d;

  assign full = (CMPW'(live_q) >= CMPW'(cap_q)) || (live_q >= CW'(DEPTH));

  assign rd_en     = cmd_i.walk && (ptr_q < live_q);
  assign match_key = (rd_key == key_q);
  assign match_new = (rd_key == new_key_q);
  assign is_slot   = cmp_vld_q && !cmd_i.shift && match_key && !hit_q;
  assign dup_set   = cmp_vld_q && !cmd_i.shift && match_new && !(match_key && !hit_q);

  assign stat_o.walk_done = (ptr_q >= live_q) && !cmp_vld_q;
  assign stat_o.do_shift  = (req_q == REQ_DEL) && hit_q;

  always_comb begin
    status_d = ST_OK;
    unique case (req_q)
      REQ_ADD: begin
        priority if (full) begin
          status_d = ST_FULL;
        end else if (hit_q) begin
          status_d = ST_ADD_DUP;
        end
      end
      REQ_DEL: status_d = hit_q ? ST_OK : ST_DEL_MISS;
      REQ_GET: status_d = hit_q ? ST_OK : ST_GET_MISS;
      REQ_UPD: begin
        priority if (!hit_q) begin
          status_d = ST_UPD_MISS;
        end else if (dup_q) begin
          status_d = ST_UPD_DUP;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign add_ok    = (req_q == REQ_ADD) && !full && !hit_q;
  assign commit_wr = cmd_i.commit && (add_ok || ((req_q == REQ_UPD) && hit_q && !dup_q));
  assign shift_wr  = cmd_i.shift && cmp_vld_q;
  assign wr_en     = commit_wr || shift_wr;

  always_comb begin
    if (shift_wr) begin
      wr_addr = IW'(cmp_idx_q - IW'(1));
      wr_key  = rd_key;
      wr_pay  = rd_pay;
    end else begin
      wr_addr = add_ok ? live_q[IW-1:0] : slot_q;
      wr_key  = add_ok ? key_q : new_key_q;
      wr_pay  = pay_q;
    end
  end

  always_comb begin
    live_d = live_q;
    if (cmd_i.commit && add_ok) begin
      live_d = live_q + CW'(1);
    end else if (cmd_i.shrink) begin
      live_d = live_q - CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.commit) begin
      ptr_d = CW'(slot_q) + CW'(1);
    end else if (rd_en) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      live_q    <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      dup_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      live_q    <= live_d;
      ptr_q     <= ptr_d;
      cmp_vld_q <= rd_en;
      if (cmd_i.load) begin
        hit_q <= 1'b0;
        dup_q <= 1'b0;
      end else begin
        if (is_slot) begin
          hit_q <= 1'b1;
        end
        if (dup_set) begin
          dup_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= ket_req_e'(req_type_i);
      key_q     <= lookup_key_i;
      new_key_q <= replacement_key_i;
      pay_q     <= entry_payload_i;
    end
    if (rd_en) begin
      cmp_idx_q <= ptr_q[IW-1:0];
    end
    if (is_slot) begin
      slot_q      <= cmp_idx_q;
      found_pay_q <= rd_pay;
    end
    if (cmd_i.commit) begin
      res_status_q <= status_d;
      res_found_q  <= ((req_q == REQ_GET) && hit_q) ? found_pay_q : '0;
    end
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_count_q  <= COUNT_W'(live_q);
    end
  end

  ket_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_key),
    .re_i    (rd_en),
    .raddr_i (ptr_q[IW-1:0]),
    .rdata_o (rd_key)
  );

  ket_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_pay),
    .re_i    (rd_en),
    .raddr_i (ptr_q[IW-1:0]),
    .rdata_o (rd_pay)
  );

  assign status_o        = out_status_q;
  assign found_payload_o = out_found_q;
  assign entry_count_o   = out_count_q;

endmodule

// ===== hdl/keyed_entry_table.sv =====
// Top level of the keyed entry table: a searched key/payload table with four requests.
//
//   Channel   Handshake                   Payload
//   --------  --------------------------  -------------------------------------------------
//   in        in_valid_i / in_stall_o     req_type_i, lookup_key_i, replacement_key_i,
//                                         entry_payload_i
//   out       out_valid_o / out_stall_i   status_o, found_payload_o, entry_count_o
//   cfg       cfg_valid_i / cfg_ready_o   cfg_data_i (capacity limit)
//
// After a request is accepted, the read walk through the key and payload memories visits
// one live entry per cycle through their single read port, then the commit step decides the
// outcome and the finish step publishes it. A delete that hits then walks again through the
// same port and moves each entry above the removed one down one place. The next request is
// taken in the idle state that follows the publish step.
// Reset clears the live entry count and sets the capacity limit to 16; the memories themselves
// are not cleared, since only live entries are ever read.
// One request is worked on at a time. A finished result sits in the output register while
// the next request is taken and searched; that request only waits at its publish step if
// the previous result has still not been taken.
module keyed_entry_table import ket_pkg::*; #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned KEY_WIDTH     = 16,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Request channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [KEY_WIDTH-1:0]     lookup_key_i,
  input  logic [KEY_WIDTH-1:0]     replacement_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] entry_payload_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [PAYLOAD_WIDTH-1:0] found_payload_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  // Capacity limit write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  ket_cmd_t  cmd;
  ket_stat_t stat;

  // Capacity writes are always accepted; the user must write only while idle (unchecked).
  assign cfg_ready_o = 1'b1;

  // The controller walks each request through scan, commit, an optional shift and publish.
  ket_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the stores, the live count, the compare stage and the result.
  ket_dp #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (req_type_i),
    .lookup_key_i      (lookup_key_i),
    .replacement_key_i (replacement_key_i),
    .entry_payload_i   (entry_payload_i),
    .status_o          (status_o),
    .found_payload_o   (found_payload_o),
    .entry_count_o     (entry_count_o)
  );

endmodule
